>>> hw/rtl/cn1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cn1_pkg;
  localparam int SCRATCH_WORDS_DEF = 131072;
  localparam int ITER_W = 21;
  localparam logic [ITER_W-1:0] ITER_RESET = 21'd524288;
  localparam logic [15:0] TWEAK_TABLE = 16'h7531;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_A_LO  = 3'd0,
    CFG_A_HI  = 3'd1,
    CFG_B_LO  = 3'd2,
    CFG_B_HI  = 3'd3,
    CFG_TWEAK = 3'd4,
    CFG_ITER  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_J_RD,
    ST_J_WAIT,
    ST_AES,
    ST_K_RD,
    ST_K_WAIT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_K_WR,
    ST_OUT
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[v];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/cn1_aes_round.sv
`timescale 1ns / 1ps
`default_nettype none
module cn1_aes_round (
  input  wire logic [127:0] w,
  input  wire logic [127:0] k,
  output logic      [127:0] o
);
  import cn1_pkg::*;
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = w[8*i +: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = t[4*c]   ^ t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3] ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3] ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3] ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3] ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) o[8*i +: 8] = m[i] ^ k[8*i +: 8];
  end
endmodule
`default_nettype wire

>>> hw/rtl/cryptonight_v1_scratchpad_loop_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: output in the next cycle; read: registered memory port, READ_WAIT, OUT.
// Run: each iteration steps ST_J_RD to ST_K_WR, set by the single-port scratchpad
// (J read, J write, K read, K write) and a 3-step 64x64 multiply on 32x32 parts.
// Loads go back to back unless out_stall; read and run hold the input until done.
// rst_n synchronous active low clears control, a, b and counters, and sets config
// to its defaults; scratchpad contents are undefined until loaded. No clearing pass.
module cryptonight_v1_scratchpad_loop_unit #(
  parameter int SCRATCH_WORDS = cn1_pkg::SCRATCH_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [16:0] in_word_index,
  input  wire logic [63:0] in_word_low,
  input  wire logic [63:0] in_word_high,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_read_low,
  output logic [63:0]      out_read_high,
  output logic             out_run_done
);
  import cn1_pkg::*;
  localparam int AW = $clog2(SCRATCH_WORDS);

  logic [127:0] mem [SCRATCH_WORDS];
  logic [127:0] rdata_r;
  logic         we;
  logic [AW-1:0] addr;
  logic [127:0] wdata;

  logic [63:0] a_lo_i_r, a_hi_i_r, b_lo_i_r, b_hi_i_r, tweak_r;
  logic [ITER_W-1:0] iter_cnt_r, iter_r;
  logic [127:0] a_r, b_r, c_r, kw_r;
  logic [AW-1:0] j_r, k_r;
  logic [63:0] p0_r, p1_r, p2_r, p3_r;
  logic [127:0] prod_r;
  state_t state_r, state_nxt;
  logic [63:0] o_lo_r, o_hi_r;
  logic o_done_r, o_valid_r;
  logic [127:0] aes_o;
  logic [63:0] vh;
  logic [3:0] sel;
  logic out_free, acc;

  cn1_aes_round u_aes (.w(rdata_r), .k(a_r), .o(aes_o));

  assign out_free = !o_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign acc = in_valid && !in_stall;
  assign out_valid = o_valid_r;
  assign out_read_low = o_lo_r;
  assign out_read_high = o_hi_r;
  assign out_run_done = o_done_r;

  assign vh = b_r[127:64] ^ c_r[127:64];
  assign sel = {vh[29:28], vh[24], 1'b0};

  always_comb begin
    we = 1'b0;
    addr = AW'(in_word_index);
    wdata = {in_word_high, in_word_low};
    case (state_r)
      ST_IDLE: we = acc && in_cmd == CMD_LOAD;
      ST_J_RD: addr = j_r;
      ST_J_WAIT: addr = j_r;
      ST_K_RD: begin
        we = 1'b1;
        addr = j_r;
        wdata = {vh ^ ({62'd0, 2'(TWEAK_TABLE >> sel)} << 28),
                 b_r[63:0] ^ c_r[63:0]};
      end
      ST_K_WAIT: addr = k_r;
      ST_K_WR: begin
        we = 1'b1;
        addr = k_r;
        wdata = {a_r[127:64] ^ tweak_r, a_r[63:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:
        if (acc && in_cmd == CMD_READ) state_nxt = ST_READ_WAIT;
        else if (acc && in_cmd == CMD_RUN)
          state_nxt = (iter_cnt_r == '0) ? ST_OUT : ST_J_RD;
      ST_READ_WAIT: state_nxt = ST_OUT;
      ST_J_RD:   state_nxt = ST_J_WAIT;
      ST_J_WAIT: state_nxt = ST_AES;
      ST_AES:    state_nxt = ST_K_RD;
      ST_K_RD:   state_nxt = ST_K_WAIT;
      ST_K_WAIT: state_nxt = ST_MUL0;
      ST_MUL0:   state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_K_WR;
      ST_K_WR:   state_nxt = (ITER_W'(iter_r + 1'b1) == iter_cnt_r) ? ST_OUT : ST_J_RD;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      o_valid_r <= 1'b0;
      a_lo_i_r <= '0; a_hi_i_r <= '0; b_lo_i_r <= '0; b_hi_i_r <= '0;
      tweak_r <= '0;
      iter_cnt_r <= ITER_RESET;
      a_r <= '0; b_r <= '0; iter_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_A_LO:  a_lo_i_r <= cfg_data;
          CFG_A_HI:  a_hi_i_r <= cfg_data;
          CFG_B_LO:  b_lo_i_r <= cfg_data;
          CFG_B_HI:  b_hi_i_r <= cfg_data;
          CFG_TWEAK: tweak_r <= cfg_data;
          CFG_ITER:  iter_cnt_r <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      o_valid_r <= (o_valid_r && out_stall)
                || (state_r == ST_IDLE && acc && (in_cmd == CMD_LOAD || in_cmd == CMD_NOP))
                || (state_r == ST_OUT && out_free);
      case (state_r)
        ST_IDLE: if (acc) begin
          if (in_cmd == CMD_LOAD || in_cmd == CMD_NOP) begin
            o_lo_r <= '0; o_hi_r <= '0; o_done_r <= 1'b0;
          end
          if (in_cmd == CMD_RUN) begin
            a_r <= {a_hi_i_r, a_lo_i_r};
            b_r <= {b_hi_i_r, b_lo_i_r};
            iter_r <= '0;
            j_r <= a_lo_i_r[AW+3:4];
            o_lo_r <= '0; o_hi_r <= '0; o_done_r <= 1'b1;
          end
          if (in_cmd == CMD_READ) o_done_r <= 1'b0;
        end
        ST_AES: begin
          c_r <= aes_o;
          k_r <= aes_o[AW+3:4];
        end
        ST_K_RD: b_r <= c_r;
        ST_K_WAIT: ;
        ST_MUL0: begin
          kw_r <= rdata_r;
          p0_r <= 64'(c_r[31:0])  * 64'(rdata_r[31:0]);
          p1_r <= 64'(c_r[31:0])  * 64'(rdata_r[63:32]);
          p2_r <= 64'(c_r[63:32]) * 64'(rdata_r[31:0]);
          p3_r <= 64'(c_r[63:32]) * 64'(rdata_r[63:32]);
        end
        ST_MUL1: prod_r <= {p3_r, p0_r} + {32'd0, p1_r, 32'd0} + {32'd0, p2_r, 32'd0};
        ST_MUL2: begin
          a_r <= {a_r[127:64] + prod_r[63:0], a_r[63:0] + prod_r[127:64]};
        end
        ST_K_WR: begin
          a_r <= a_r ^ kw_r;
          iter_r <= iter_r + 1'b1;
          j_r <= a_r[AW+3:4] ^ kw_r[AW+3:4];
        end
        ST_READ_WAIT: begin
          o_lo_r <= rdata_r[63:0];
          o_hi_r <= rdata_r[127:64];
        end
        default: ;
      endcase
    end
  end

  property p_stall_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |-> in_stall;
  endproperty
  a_stall_busy: assert property (p_stall_busy) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_run_done)))
    else $error("output beat dropped");
  a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_WR) |=> o_done_r) else $error("run flag lost");
endmodule
`default_nettype wire
